// ===== rtl/tcpff_pkg.sv =====
package tcpff_pkg;

  // Bytes of link header ahead of the IPv4 header.
  localparam int unsigned LINK_HEADER_BYTES = 14;
  // Width of the saturating frame counters.
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned POS_W   = 7;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned PFLT_W  = 17;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [PFLT_W-1:0] PORT_ANY = '1;

  // Fixed IPv4 field offsets inside the frame.
  localparam logic [POS_W-1:0] OFS_IHL      = POS_W'(LINK_HEADER_BYTES);
  localparam logic [POS_W-1:0] OFS_PROTO    = POS_W'(LINK_HEADER_BYTES + 9);
  localparam logic [POS_W-1:0] OFS_SRC_LO   = POS_W'(LINK_HEADER_BYTES + 12);
  localparam logic [POS_W-1:0] OFS_SRC_HI   = POS_W'(LINK_HEADER_BYTES + 15);
  localparam logic [POS_W-1:0] OFS_DST_LO   = POS_W'(LINK_HEADER_BYTES + 16);
  localparam logic [POS_W-1:0] OFS_DST_HI   = POS_W'(LINK_HEADER_BYTES + 19);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ADDR  = 3'd0,
    CFG_SRC_EN    = 3'd1,
    CFG_DST_ADDR  = 3'd2,
    CFG_DST_EN    = 3'd3,
    CFG_SPORT_FLT = 3'd4,
    CFG_DPORT_FLT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic              src_en;
    logic [ADDR_W-1:0] dst_addr;
    logic              dst_en;
    logic [PFLT_W-1:0] sport_flt;
    logic [PFLT_W-1:0] dport_flt;
  } filter_cfg_t;

  typedef struct packed {
    logic is_tcp;
    logic matched;
  } frame_flags_t;

  typedef struct packed {
    logic [OUT_W-1:0] frames_seen;
    logic [OUT_W-1:0] tcp_frames;
    logic [OUT_W-1:0] matched_frames;
    logic             frame_was_tcp;
    logic             frame_matched;
  } result_t;

endpackage

// ===== rtl/tcpff_byte_if.sv =====
interface tcpff_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

// ===== rtl/tcpff_result_if.sv =====
interface tcpff_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] frames_seen;
  logic [31:0] tcp_frames;
  logic [31:0] matched_frames;
  logic        frame_was_tcp;
  logic        frame_matched;

  modport source (
    output valid, output frames_seen, output tcp_frames, output matched_frames,
    output frame_was_tcp, output frame_matched, input ready
  );
  modport sink (
    input valid, input frames_seen, input tcp_frames, input matched_frames,
    input frame_was_tcp, input frame_matched, output ready
  );
endinterface

// ===== rtl/tcpff_capture.sv =====
module tcpff_capture import tcpff_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   byte_i,
  input  logic         eof_i,
  input  filter_cfg_t  cfg_i,
  output frame_flags_t flags_o
);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [3:0]        hdr_words_q, hdr_words_d;
  logic              proto_vld_q, proto_vld_d;
  logic [7:0]        proto_q, proto_d;
  logic [ADDR_W-1:0] src_addr_q, src_addr_d;
  logic [ADDR_W-1:0] dst_addr_q, dst_addr_d;
  logic [PORT_W-1:0] sport_q, sport_d;
  logic [PORT_W-1:0] dport_q, dport_d;
  logic              complete_q, complete_d;

  // Frame state with the current byte folded in, before any end-of-frame clear.
  logic [3:0]        hw_upd;
  logic              pvld_upd;
  logic [7:0]        proto_upd;
  logic [ADDR_W-1:0] src_upd, dst_upd;
  logic [PORT_W-1:0] sport_upd, dport_upd;
  logic              cmpl_upd;
  logic [POS_W-1:0]  port_base;
  logic              src_ok, dst_ok, sport_ok, dport_ok, is_tcp;

  always_comb begin
    hw_upd    = hdr_words_q;
    pvld_upd  = proto_vld_q;
    proto_upd = proto_q;
    src_upd   = src_addr_q;
    dst_upd   = dst_addr_q;
    sport_upd = sport_q;
    dport_upd = dport_q;
    cmpl_upd  = complete_q;

    if (pos_q == OFS_IHL) begin
      hw_upd = (byte_i[3:0] < MIN_HDR_WORDS) ? MIN_HDR_WORDS : byte_i[3:0];
    end else if (pos_q == OFS_PROTO) begin
      pvld_upd  = 1'b1;
      proto_upd = byte_i;
    end else if (pos_q >= OFS_SRC_LO && pos_q <= OFS_SRC_HI) begin
      src_upd = {src_addr_q[ADDR_W-9:0], byte_i};
    end else if (pos_q >= OFS_DST_LO && pos_q <= OFS_DST_HI) begin
      dst_upd = {dst_addr_q[ADDR_W-9:0], byte_i};
    end

    // The TCP header always starts well past the length byte, so the stored
    // header length is already settled whenever a port byte can arrive.
    port_base = OFS_IHL + {1'b0, hdr_words_q, 2'b00};
    if (pos_q == port_base || pos_q == port_base + POS_W'(1)) begin
      sport_upd = {sport_q[PORT_W-9:0], byte_i};
    end else if (pos_q == port_base + POS_W'(2) || pos_q == port_base + POS_W'(3)) begin
      dport_upd = {dport_q[PORT_W-9:0], byte_i};
      if (pos_q == port_base + POS_W'(3)) begin
        cmpl_upd = 1'b1;
      end
    end
  end

  always_comb begin
    is_tcp   = pvld_upd && (proto_upd == PROTO_TCP);
    src_ok   = !cfg_i.src_en || (src_upd == cfg_i.src_addr);
    dst_ok   = !cfg_i.dst_en || (dst_upd == cfg_i.dst_addr);
    sport_ok = (cfg_i.sport_flt == PORT_ANY) ||
               (!cfg_i.sport_flt[PFLT_W-1] && cfg_i.sport_flt[PORT_W-1:0] == sport_upd);
    dport_ok = (cfg_i.dport_flt == PORT_ANY) ||
               (!cfg_i.dport_flt[PFLT_W-1] && cfg_i.dport_flt[PORT_W-1:0] == dport_upd);
    flags_o.is_tcp  = is_tcp;
    flags_o.matched = is_tcp && cmpl_upd && src_ok && dst_ok && sport_ok && dport_ok;
  end

  always_comb begin
    pos_d       = pos_q;
    hdr_words_d = hdr_words_q;
    proto_vld_d = proto_vld_q;
    proto_d     = proto_q;
    src_addr_d  = src_addr_q;
    dst_addr_d  = dst_addr_q;
    sport_d     = sport_q;
    dport_d     = dport_q;
    complete_d  = complete_q;
    if (accept_i) begin
      if (eof_i) begin
        pos_d       = '0;
        hdr_words_d = MIN_HDR_WORDS;
        proto_vld_d = 1'b0;
        proto_d     = '0;
        src_addr_d  = '0;
        dst_addr_d  = '0;
        sport_d     = '0;
        dport_d     = '0;
        complete_d  = 1'b0;
      end else begin
        pos_d       = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
        hdr_words_d = hw_upd;
        proto_vld_d = pvld_upd;
        proto_d     = proto_upd;
        src_addr_d  = src_upd;
        dst_addr_d  = dst_upd;
        sport_d     = sport_upd;
        dport_d     = dport_upd;
        complete_d  = cmpl_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_words_q <= MIN_HDR_WORDS;
      proto_vld_q <= 1'b0;
      proto_q     <= '0;
      src_addr_q  <= '0;
      dst_addr_q  <= '0;
      sport_q     <= '0;
      dport_q     <= '0;
      complete_q  <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hdr_words_q <= hdr_words_d;
      proto_vld_q <= proto_vld_d;
      proto_q     <= proto_d;
      src_addr_q  <= src_addr_d;
      dst_addr_q  <= dst_addr_d;
      sport_q     <= sport_d;
      dport_q     <= dport_d;
      complete_q  <= complete_d;
    end
  end

endmodule

// ===== rtl/tcp_flow_filter_counter_unit.sv =====
// IPv4/TCP flow filter and frame counter.
// The byte channel (byte_if) carries one frame byte per request with an
// end-of-frame flag on the last byte. The header fields are captured on the
// fly; on the last byte the frame is classified and the three saturating
// counters are bumped. Exactly one result request per frame is registered in
// the result queue for the result channel (res_if) when the last byte is accepted.
// Throughput is one byte per cycle while the queue is not full; the capture and
// compare logic sits between the frame-state registers and a two-entry result queue.
// The filters are written through cfg_we_i / cfg_index_i / cfg_wdata_i; the user
// must write them only between frames, as the block does not enforce it; writes to an unknown index are dropped.
// Reset clears the counters and frame state, zeroes the address filters,
// disables them, and sets both port filters to match any port.
// If the receiver stalls, results wait in the queue; bytes keep flowing
// until both queue entries are full, and only then is ready dropped.
module tcp_flow_filter_counter_unit import tcpff_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcpff_byte_if.sink            byte_if,
  tcpff_result_if.source        res_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  filter_cfg_t cfg_q;
  frame_flags_t flags;
  logic accept, push, pop;

  logic [COUNT_WIDTH-1:0] frames_q, frames_d;
  logic [COUNT_WIDTH-1:0] tcp_q, tcp_d;
  logic [COUNT_WIDTH-1:0] match_q, match_d;

  result_t   slot_q [2];
  result_t   new_res;
  logic      rd_ptr_q, wr_ptr_q;
  logic [1:0] count_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_addr  <= '0;
      cfg_q.src_en    <= 1'b0;
      cfg_q.dst_addr  <= '0;
      cfg_q.dst_en    <= 1'b0;
      cfg_q.sport_flt <= PORT_ANY;
      cfg_q.dport_flt <= PORT_ANY;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SRC_ADDR:  cfg_q.src_addr  <= cfg_wdata_i[ADDR_W-1:0];
        CFG_SRC_EN:    cfg_q.src_en    <= cfg_wdata_i[0];
        CFG_DST_ADDR:  cfg_q.dst_addr  <= cfg_wdata_i[ADDR_W-1:0];
        CFG_DST_EN:    cfg_q.dst_en    <= cfg_wdata_i[0];
        CFG_SPORT_FLT: cfg_q.sport_flt <= cfg_wdata_i[PFLT_W-1:0];
        CFG_DPORT_FLT: cfg_q.dport_flt <= cfg_wdata_i[PFLT_W-1:0];
        default: ;
      endcase
    end
  end

  assign byte_if.ready = (count_q != 2'd2);
  assign accept = byte_if.valid && byte_if.ready;
  assign push   = accept && byte_if.end_of_frame;
  assign pop    = res_if.valid && res_if.ready;

  tcpff_capture u_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (byte_if.frame_byte),
    .eof_i    (byte_if.end_of_frame),
    .cfg_i    (cfg_q),
    .flags_o  (flags)
  );

  // Saturating counters, advanced on the last byte of each frame.
  always_comb begin
    frames_d = (&frames_q) ? frames_q : frames_q + COUNT_WIDTH'(1);
    tcp_d    = (flags.is_tcp && !(&tcp_q)) ? tcp_q + COUNT_WIDTH'(1) : tcp_q;
    match_d  = (flags.matched && !(&match_q)) ? match_q + COUNT_WIDTH'(1) : match_q;

    new_res.frames_seen    = OUT_W'(frames_d);
    new_res.tcp_frames     = OUT_W'(tcp_d);
    new_res.matched_frames = OUT_W'(match_d);
    new_res.frame_was_tcp  = flags.is_tcp;
    new_res.frame_matched  = flags.matched;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
      tcp_q    <= '0;
      match_q  <= '0;
    end else if (push) begin
      frames_q <= frames_d;
      tcp_q    <= tcp_d;
      match_q  <= match_d;
    end
  end

  // Two-entry result queue.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign res_if.valid          = (count_q != 2'd0);
  assign res_if.frames_seen    = slot_q[rd_ptr_q].frames_seen;
  assign res_if.tcp_frames     = slot_q[rd_ptr_q].tcp_frames;
  assign res_if.matched_frames = slot_q[rd_ptr_q].matched_frames;
  assign res_if.frame_was_tcp  = slot_q[rd_ptr_q].frame_was_tcp;
  assign res_if.frame_matched  = slot_q[rd_ptr_q].frame_matched;

endmodule
